// File: rtl/spc_pkg.sv
// Shared types and constants for the sinusoid phase continuation block.
// No dependencies; imported by every module of the block.
`default_nettype none

package spc_pkg;

    localparam int PHASE_BITS = 24;
    localparam int TIME_BITS  = 32;
    localparam int ID_BITS    = 6;

    localparam logic MODE_PASS = 1'b0;
    localparam logic MODE_CONT = 1'b1;

    typedef struct packed {
        logic [TIME_BITS-1:0]  frame_time;
        logic                  has_track;
        logic [ID_BITS-1:0]    track_id;
        logic [PHASE_BITS-1:0] peak_freq;
        logic [PHASE_BITS-1:0] peak_phase;
        logic                  last_in_frame;
    } spc_in_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase_out;
        logic                  last_out;
    } spc_out_t;

    // one stored track entry: phase and frequency of the previous frame
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [PHASE_BITS-1:0] freq;
    } spc_entry_t;

endpackage

`default_nettype wire

// File: rtl/sinusoid_phase_continuation_top.sv
// Sinusoid phase continuation, top level. Uses spc_pkg, spc_track_mem, spc_phase_calc.
// Registered path: input stage, then result register. Throughput: one word per cycle
// unless m_ready stalls the result; track store read at accept, written as the result registers.
// Reset: mode to continuation, bank 0, previous frame time 0, all track valid bits
// cleared at once; store contents stay undefined until written. No clearing pass.
`default_nettype none

module sinusoid_phase_continuation_top #(
    parameter int MAX_TRACKS = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire spc_pkg::spc_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output spc_pkg::spc_out_t      m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data
);
    import spc_pkg::*;

    localparam int IDX_W  = $clog2(MAX_TRACKS);
    localparam int ADDR_W = IDX_W + 1;

    // control state
    logic                  mode_reg;
    logic                  bank_reg;
    logic [TIME_BITS-1:0]  prev_time_reg;
    logic [MAX_TRACKS-1:0] valid_reg [2];

    // input stage
    logic                  s1_valid_reg;
    logic                  s1_pass_reg;
    logic                  s1_hit_reg;
    logic                  s1_use_id_reg;
    logic [PHASE_BITS:0]   s1_dt_reg;
    logic [PHASE_BITS-1:0] s1_freq_reg;
    logic [PHASE_BITS-1:0] s1_phase_in_reg;
    logic                  s1_last_reg;
    logic [ADDR_W-1:0]     s1_wr_addr_reg;

    // result register
    logic                  m_valid_reg;
    spc_out_t              m_data_reg;

    logic                  adv;
    logic                  s_fire;
    logic                  cont;
    logic [31:0]           id32;
    logic                  use_id;
    logic [IDX_W-1:0]      idx;
    logic [TIME_BITS-1:0]  dt_next;
    logic                  hit_next;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    spc_entry_t            wr_data;
    spc_entry_t            rd_data;
    logic [PHASE_BITS-1:0] calc_phase;

    assign cfg_ready = 1'b1;
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || adv;
    assign s_fire    = s_valid && s_ready;
    assign cont      = (mode_reg == MODE_CONT);

    assign id32     = 32'(s_data.track_id);
    assign use_id   = s_data.has_track && (id32 < 32'(MAX_TRACKS));
    assign idx      = id32[IDX_W-1:0];
    assign dt_next  = s_data.frame_time - prev_time_reg;
    assign hit_next = use_id && valid_reg[bank_reg][idx];
    assign rd_addr  = {bank_reg, idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_CONT;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    // bank state moves at accept; pass words leave it alone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg      <= 1'b0;
            prev_time_reg <= '0;
            valid_reg[0]  <= '0;
            valid_reg[1]  <= '0;
        end else if (s_fire && cont) begin
            if (use_id) begin
                valid_reg[~bank_reg][idx] <= 1'b1;
            end
            if (s_data.last_in_frame) begin
                valid_reg[bank_reg] <= '0;
                bank_reg            <= ~bank_reg;
                prev_time_reg       <= s_data.frame_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_pass_reg     <= !cont;
            s1_hit_reg      <= hit_next;
            s1_use_id_reg   <= use_id;
            s1_dt_reg       <= dt_next[PHASE_BITS:0];
            s1_freq_reg     <= s_data.peak_freq;
            s1_phase_in_reg <= s_data.peak_phase;
            s1_last_reg     <= s_data.last_in_frame;
            s1_wr_addr_reg  <= {~bank_reg, idx};
        end
    end

    spc_track_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (s1_wr_addr_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    spc_phase_calc u_calc (
        .hit   (s1_hit_reg),
        .dt    (s1_dt_reg),
        .freq  (s1_freq_reg),
        .prev  (rd_data),
        .phase (calc_phase)
    );

    assign wr_en   = adv && s1_valid_reg && !s1_pass_reg && s1_use_id_reg;
    assign wr_data = {calc_phase, s1_freq_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg) begin
            m_data_reg.phase_out <= s1_pass_reg ? s1_phase_in_reg : calc_phase;
            m_data_reg.last_out  <= s1_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !adv) |-> !s_ready)
        else $error("input stage overrun while result stalled");

    a_wr_source: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (s1_valid_reg && !s1_pass_reg))
        else $error("track store written without a continuation word");

    a_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && cont && s_data.last_in_frame) |=> (bank_reg != $past(bank_reg)))
        else $error("bank did not swap at frame end");

    a_pass_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !cont) |=> ($stable(bank_reg) && $stable(prev_time_reg)))
        else $error("pass word changed bank state");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result raised without a word in the input stage");
`endif

endmodule

`default_nettype wire

// File: rtl/spc_track_mem.sv
// Two-bank track store: one write and one registered read per cycle.
// A write to the address read in the same cycle is forwarded. Uses spc_pkg.
`default_nettype none

module spc_track_mem #(
    parameter int ADDR_W = 7
) (
    input  wire logic                aclk,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire spc_pkg::spc_entry_t wr_data,
    output spc_pkg::spc_entry_t      rd_data
);
    import spc_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    spc_entry_t mem [DEPTH];
    spc_entry_t rd_q_reg;
    spc_entry_t byp_data_reg;
    logic       byp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

`default_nettype wire

// File: rtl/spc_phase_calc.sv
// Phase arithmetic for one peak: continued track or new track, modulo one turn.
// Combinational; uses spc_pkg.
`default_nettype none

module spc_phase_calc (
    input  wire logic                         hit,
    input  wire logic [spc_pkg::PHASE_BITS:0] dt,
    input  wire logic [spc_pkg::PHASE_BITS-1:0] freq,
    input  wire spc_pkg::spc_entry_t          prev,
    output logic [spc_pkg::PHASE_BITS-1:0]    phase
);
    import spc_pkg::*;

    localparam int W1 = PHASE_BITS + 1;

    logic [W1-1:0]           sum_f;
    logic [2*W1-1:0]         prod_c;
    logic [2*PHASE_BITS-1:0] prod_n;
    logic [W1:0]             inc_full;
    logic [PHASE_BITS-1:0]   phase_cont;

    always_comb begin
        sum_f    = {1'b0, prev.freq} + {1'b0, freq};
        prod_c   = sum_f * dt;
        prod_n   = freq * dt[PHASE_BITS-1:0];
        // half of the summed frequency step, rounded half up
        inc_full = {1'b0, prod_c[W1-1:0]} + {{W1{1'b0}}, 1'b1};
        phase_cont = prev.phase + inc_full[PHASE_BITS:1];
        phase    = hit ? phase_cont : prod_n[PHASE_BITS-1:0];
    end

endmodule

`default_nettype wire
